@@ src/hds_pkg.sv @@
// Shared types and constants for the heredoc delimiter scanner.
`default_nettype none

package hds_pkg;

   // Default size of the delimiter store (bytes); one less is the longest delimiter.
   localparam int DELIM_BYTES_DEF = 128;

   // Entries in the queue between the front and back parts.
   localparam int QUEUE_DEPTH = 2;

   // Character codes.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h27;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_MSKIP,
      PH_MCOLLECT,
      PH_BODY
   } hds_phase_type;

   // One classified character, as it travels through the queue.
   typedef struct packed {
      logic [7:0] ch;
      logic       start_req;
      logic       want_marker;
      logic       is_blank;     // space or tab
      logic       is_nul;
      logic       is_eol;       // LF or CR
      logic       is_quote;
      logic       ends_mark;    // NUL, quote or C whitespace
   } hds_item_type;

endpackage

`default_nettype wire

@@ src/hds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module hds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = hds_pkg::DELIM_BYTES_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

@@ src/hds_front.sv @@
// Front part: accepts characters and classifies them for the back part.
`default_nettype none

module hds_front (
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_ch,
   input  wire logic                  req_start_req,
   input  wire logic                  req_want_marker,
   input  wire logic                  q_full,
   output logic                       q_push,
   output hds_pkg::hds_item_type      q_item
);

   logic blank;
   logic eol;
   logic nul;
   logic quote;

   always_comb begin
      blank = (req_ch == hds_pkg::CH_SPACE) || (req_ch == hds_pkg::CH_TAB);
      eol   = (req_ch == hds_pkg::CH_LF) || (req_ch == hds_pkg::CH_CR);
      nul   = (req_ch == hds_pkg::CH_NUL);
      quote = (req_ch == hds_pkg::CH_QUOTE);

      q_item.ch          = req_ch;
      q_item.start_req   = req_start_req;
      q_item.want_marker = req_want_marker;
      q_item.is_blank    = blank;
      q_item.is_nul      = nul;
      q_item.is_eol      = eol;
      q_item.is_quote    = quote;
      q_item.ends_mark   = nul || quote || blank || eol ||
                           (req_ch == hds_pkg::CH_VT) || (req_ch == hds_pkg::CH_FF);
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

`default_nettype wire

@@ src/hds_queue.sv @@
// Short register queue between the front and back parts.
`default_nettype none

module hds_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire hds_pkg::hds_item_type push_item,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       pop_valid,
   output hds_pkg::hds_item_type      pop_item
);

   localparam int PW = $clog2(hds_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(hds_pkg::QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(hds_pkg::QUEUE_DEPTH);

   hds_pkg::hds_item_type entry_ff [hds_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_FULL);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ src/hds_back.sv @@
// Back part: scan state machine, delimiter store and result register.
`default_nettype none

module hds_back #(
   parameter int DELIM_BYTES = hds_pkg::DELIM_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire hds_pkg::hds_item_type q_item,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_skipped,
   output logic                       rsp_end_after,
   output logic                       rsp_done_res,
   output logic                       rsp_success,
   output logic                       rsp_token_kind
);

   localparam int MIW = $clog2(DELIM_BYTES);
   localparam logic [MIW-1:0] MI_LAST = MIW'(DELIM_BYTES - 1);

   hds_pkg::hds_phase_type phase_ff, phase_in;
   logic [MIW-1:0] mi_ff, mi_in;       // bytes collected or matched
   logic [MIW-1:0] dl_ff, dl_in;       // held delimiter length
   logic           ls_ff, ls_in;       // at a line start / inside a prefix match
   logic [7:0]     byte0_ff, byte0_in; // copy of store entry 0
   logic           rsp_valid_ff;

   logic           fire;
   logic           wr_en;
   logic [MIW-1:0] wr_addr;
   logic [MIW-1:0] rd_addr;
   logic [7:0]     rd_data;
   logic [7:0]     cmp_byte;
   logic           o_skip, o_end, o_done, o_ok, o_kind;

   hds_ram #(
      .WIDTH (8),
      .DEPTH (DELIM_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (q_item.ch),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign fire      = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign q_pop     = fire;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      phase_in = phase_ff;
      mi_in    = mi_ff;
      dl_in    = dl_ff;
      ls_in    = ls_ff;
      byte0_in = byte0_ff;
      wr_en    = 1'b0;
      wr_addr  = mi_ff;
      cmp_byte = rd_data;
      o_skip   = 1'b0;
      o_end    = 1'b0;
      o_done   = 1'b0;
      o_ok     = 1'b0;
      o_kind   = 1'b0;

      if (fire) begin
         if (q_item.start_req) begin
            mi_in = '0;
            ls_in = 1'b1;
            if (q_item.want_marker) begin
               phase_in = hds_pkg::PH_MSKIP;
            end else if ((dl_ff == '0) || q_item.is_quote) begin
               phase_in = hds_pkg::PH_IDLE;
               o_kind   = 1'b1;
               o_done   = 1'b1;
            end else begin
               phase_in = hds_pkg::PH_BODY;
            end
         end

         if (phase_in == hds_pkg::PH_MSKIP) begin
            if (q_item.is_blank) begin
               o_skip = 1'b1;
            end else begin
               phase_in = hds_pkg::PH_MCOLLECT;
            end
         end

         // entry 0 comes from its own copy; others from the registered store read
         cmp_byte = (mi_in == '0) ? byte0_ff : rd_data;

         unique case (phase_in)
            hds_pkg::PH_MCOLLECT: begin
               if (q_item.ends_mark) begin
                  o_done = 1'b1;
                  if (mi_in != '0) begin
                     dl_in = mi_in;
                     o_ok  = 1'b1;
                     o_end = 1'b1;
                  end
                  phase_in = hds_pkg::PH_IDLE;
               end else begin
                  if (mi_in != MI_LAST) begin
                     wr_en   = 1'b1;
                     wr_addr = mi_in;
                     if (mi_in == '0) begin
                        byte0_in = q_item.ch;
                     end
                     mi_in = mi_in + 1'b1;
                  end
                  o_end = 1'b1;
               end
            end
            hds_pkg::PH_BODY: begin
               o_kind = 1'b1;
               if (ls_in && (mi_in >= dl_ff)) begin
                  if (q_item.is_nul || q_item.is_eol) begin
                     o_done = 1'b1;
                     o_ok   = 1'b1;
                  end else begin
                     o_end = 1'b1;
                     ls_in = 1'b0;
                     mi_in = '0;
                  end
               end else if (q_item.is_nul) begin
                  o_done = 1'b1;
                  o_ok   = 1'b1;
                  o_end  = 1'b1;
               end else if (ls_in && (q_item.ch == cmp_byte)) begin
                  mi_in = mi_in + 1'b1;
               end else begin
                  o_end = 1'b1;
                  ls_in = q_item.is_eol;
                  mi_in = '0;
               end
               if (o_done) begin
                  dl_in    = '0;
                  phase_in = hds_pkg::PH_IDLE;
                  mi_in    = '0;
                  ls_in    = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // fetch the entry the next character will compare against
      rd_addr = mi_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= hds_pkg::PH_IDLE;
         mi_ff        <= '0;
         dl_ff        <= '0;
         ls_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         mi_ff    <= mi_in;
         dl_ff    <= dl_in;
         ls_ff    <= ls_in;
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= q_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      if (fire) begin
         rsp_skipped    <= o_skip;
         rsp_end_after  <= o_end;
         rsp_done_res   <= o_done;
         rsp_success    <= o_ok;
         rsp_token_kind <= o_kind;
      end
   end

endmodule

`default_nettype wire

@@ src/heredoc_delimiter_scanner_core.sv @@
// Top level of the heredoc delimiter scanner.
//
//   Channel  Dir  Handshake            Payload
//   req      in   req_valid/req_stall  req_ch[7:0], req_start_req, req_want_marker
//   rsp      out  rsp_valid/rsp_stall  rsp_skipped, rsp_end_after, rsp_done_res,
//                                      rsp_success, rsp_token_kind
//
// One transaction in gives exactly one transaction out, in order.
// Throughput: one character per cycle while rsp_stall is low, set by the back part's state update
// (one compare against the delimiter store per character).
// An accepted input passes through a queue entry, then the result register,
// before its result is valid.
// The store entry for the next character is read ahead, at the
// updated match index; entry 0 is held in a register so a new body scan can
// compare on its first character.
// Reset is synchronous, active high; it clears the scan state and queue.
// The store needs no clearing pass: only written entries are ever compared.
// rsp_stall holds the result register; the two-entry queue absorbs the
// in-flight transaction, and req_stall rises only when the queue is full.
`default_nettype none

module heredoc_delimiter_scanner_core #(
   parameter int DELIM_BYTES = hds_pkg::DELIM_BYTES_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_ch,
   input  wire logic       req_start_req,
   input  wire logic       req_want_marker,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_skipped,
   output logic            rsp_end_after,
   output logic            rsp_done_res,
   output logic            rsp_success,
   output logic            rsp_token_kind
);

   hds_pkg::hds_item_type push_item;
   hds_pkg::hds_item_type pop_item;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_valid;

   // classify the incoming character
   hds_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_start_req   (req_start_req),
      .req_want_marker (req_want_marker),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (push_item)
   );

   // decouples acceptance from the scan
   hds_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_item  (pop_item)
   );

   // scan state, delimiter store, result register
   hds_back #(
      .DELIM_BYTES (DELIM_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_skipped    (rsp_skipped),
      .rsp_end_after  (rsp_end_after),
      .rsp_done_res   (rsp_done_res),
      .rsp_success    (rsp_success),
      .rsp_token_kind (rsp_token_kind)
   );

endmodule

`default_nettype wire

@@ src/hds_checker.sv @@
// Port-level checker for the heredoc delimiter scanner, with its bind.
`default_nettype none

module hds_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_skipped,
   input wire logic       rsp_end_after,
   input wire logic       rsp_done_res,
   input wire logic       rsp_success,
   input wire logic       rsp_token_kind
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_skipped) &&
         $stable(rsp_end_after) && $stable(rsp_done_res) &&
         $stable(rsp_success) && $stable(rsp_token_kind))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

   // success only on a finishing transaction
   a_ok_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success |-> rsp_done_res)
      else $error("success without done");

   // a recognized marker always ends after the collected bytes
   a_marker_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_success && !rsp_token_kind |-> rsp_end_after)
      else $error("marker success without token end");

   // a skipped blank carries no other outcome
   a_skip_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_skipped |-> !rsp_token_kind && !rsp_done_res && !rsp_end_after)
      else $error("skipped blank with other flags");

endmodule

bind heredoc_delimiter_scanner_core hds_checker u_hds_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_skipped     (rsp_skipped),
   .rsp_end_after   (rsp_end_after),
   .rsp_done_res    (rsp_done_res),
   .rsp_success     (rsp_success),
   .rsp_token_kind  (rsp_token_kind)
);

`default_nettype wire

@@ tb/sv/heredoc_delimiter_scanner_core_test.sv @@
// Self-checking testbench for the heredoc delimiter scanner core.
`timescale 1ns / 1ps

module heredoc_delimiter_scanner_core_test;

   localparam int DELIM_BYTES = hds_pkg::DELIM_BYTES_DEF;
   localparam int RANDOM_ITEMS = 240;
   localparam int PHASE_ITEMS = 60;      // consumed items per idling phase
   localparam int HOLD_CYCLES = 40;      // one long receiver hold-off
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic skipped;
      logic end_after;
      logic done_res;
      logic success;
      logic token_kind;
   } scan_flags_type;

   // Tracks the scanner state and the flags each transaction should produce.
   class scan_tracker;
      logic [7:0]             store [DELIM_BYTES];
      logic [6:0]             delim_len;
      hds_pkg::hds_phase_type phase;
      logic [6:0]             match_idx;
      logic                   line_start;
      scan_flags_type         expected_flags [$];
      int                     errors;

      function new();
         delim_len  = '0;
         phase      = hds_pkg::PH_IDLE;
         match_idx  = '0;
         line_start = 1'b1;
         errors     = 0;
      endfunction

      static function bit marker_stop(logic [7:0] c);
         return c inside {hds_pkg::CH_NUL, hds_pkg::CH_QUOTE, hds_pkg::CH_SPACE,
                          hds_pkg::CH_TAB, hds_pkg::CH_LF, hds_pkg::CH_VT,
                          hds_pkg::CH_FF, hds_pkg::CH_CR};
      endfunction

      function scan_flags_type predict_scan(logic [7:0] c, logic start, logic want_marker);
         scan_flags_type f;
         f = '0;
         // A start abandons whatever runs; a failed body start never enters a phase.
         if (start) begin
            match_idx  = '0;
            line_start = 1'b1;
            if (want_marker) begin
               phase = hds_pkg::PH_MSKIP;
            end else if (delim_len == 0 || c == hds_pkg::CH_QUOTE) begin
               phase        = hds_pkg::PH_IDLE;
               f.token_kind = 1'b1;
               f.done_res   = 1'b1;
            end else begin
               phase = hds_pkg::PH_BODY;
            end
         end
         if (phase == hds_pkg::PH_MSKIP) begin
            if (c == hds_pkg::CH_SPACE || c == hds_pkg::CH_TAB)
               f.skipped = 1'b1;
            else
               phase = hds_pkg::PH_MCOLLECT;
         end
         if (phase == hds_pkg::PH_MCOLLECT) begin
            if (marker_stop(c)) begin
               f.done_res = 1'b1;
               if (match_idx != 0) begin
                  delim_len   = match_idx;
                  f.success   = 1'b1;
                  f.end_after = 1'b1;
               end
               phase = hds_pkg::PH_IDLE;
            end else begin
               // bytes past the store are consumed, not kept
               if (int'(match_idx) + 1 < DELIM_BYTES) begin
                  store[match_idx] = c;
                  match_idx++;
               end
               f.end_after = 1'b1;
            end
         end else if (phase == hds_pkg::PH_BODY) begin
            f.token_kind = 1'b1;
            if (line_start && match_idx >= delim_len) begin
               // whole delimiter matched: a line end or NUL closes the body before the line
               if (c == hds_pkg::CH_NUL || c == hds_pkg::CH_LF || c == hds_pkg::CH_CR) begin
                  f.done_res = 1'b1;
                  f.success  = 1'b1;
               end else begin
                  f.end_after = 1'b1;
                  line_start  = 1'b0;
                  match_idx   = '0;
               end
            end else if (c == hds_pkg::CH_NUL) begin
               f.done_res  = 1'b1;
               f.success   = 1'b1;
               f.end_after = 1'b1;
            end else if (line_start && c == store[match_idx]) begin
               match_idx++;
            end else begin
               f.end_after = 1'b1;
               line_start  = (c == hds_pkg::CH_LF || c == hds_pkg::CH_CR);
               match_idx   = '0;
            end
            if (f.done_res) begin
               delim_len  = '0;
               phase      = hds_pkg::PH_IDLE;
               match_idx  = '0;
               line_start = 1'b1;
            end
         end
         return f;
      endfunction

      // Returns 1 when the character does real work (not an ignored idle char).
      function bit note_char(logic [7:0] c, logic start, logic want_marker);
         bit counts;
         counts = start || phase != hds_pkg::PH_IDLE;
         expected_flags.push_back(predict_scan(c, start, want_marker));
         return counts;
      endfunction

      function void compare_bit(string name, logic want, logic got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_flags(scan_flags_type got);
         scan_flags_type want;
         if (expected_flags.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %b", $time, got);
            errors++;
            return;
         end
         want = expected_flags.pop_front();
         compare_bit("skipped", want.skipped, got.skipped);
         compare_bit("end_after", want.end_after, got.end_after);
         compare_bit("done_res", want.done_res, got.done_res);
         compare_bit("success", want.success, got.success);
         compare_bit("token_kind", want.token_kind, got.token_kind);
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_ch = '0;
   logic       req_start_req = 1'b0;
   logic       req_want_marker = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_skipped;
   logic       rsp_end_after;
   logic       rsp_done_res;
   logic       rsp_success;
   logic       rsp_token_kind;

   scan_tracker book;
   int          used_items = 0;
   int          send_idle_pct = 0;   // owned by the stimulus process
   int          stall_pct = 0;       // written by stimulus, read by the receiver
   logic        pressure_on = 1'b0;
   int          hold_count = 0;      // owned by the receiver
   int          cycle_count;

   heredoc_delimiter_scanner_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_start_req   (req_start_req),
      .req_want_marker (req_want_marker),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_skipped     (rsp_skipped),
      .rsp_end_after   (rsp_end_after),
      .rsp_done_res    (rsp_done_res),
      .rsp_success     (rsp_success),
      .rsp_token_kind  (rsp_token_kind)
   );

   always #4 clock = ~clock;

   // Receiver: random stalls, plus one long hold-off once pressure is armed.
   always @(posedge clock) begin
      if (pressure_on && hold_count < HOLD_CYCLES) begin
         hold_count <= hold_count + 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Handshake signals are steady mid-cycle, so sample on the falling edge.
   always @(negedge clock) begin : watch_rsp
      scan_flags_type seen;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_skipped, rsp_end_after, rsp_done_res, rsp_success, rsp_token_kind};
         book.check_flags(seen);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic set_idling(input int mode);
      case (mode)
         0: begin
            send_idle_pct = 0;
            stall_pct <= 0;
         end
         1: begin
            send_idle_pct = 83;
            stall_pct <= 0;
         end
         2: begin
            send_idle_pct = 0;
            stall_pct <= 83;
         end
         default: begin
            send_idle_pct = 37;
            stall_pct <= 37;
         end
      endcase
   endtask

   // One transaction; called and returns at a rising edge.
   task automatic send_char(input logic [7:0] c, input logic start, input logic want_marker);
      logic took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_ch          <= c;
      req_start_req   <= start;
      req_want_marker <= want_marker;
      do begin
         @(negedge clock);
         took = !req_stall;
         @(posedge clock);
      end while (!took);
      if (book.note_char(c, start, want_marker))
         used_items++;
   endtask

   // Start flag only on the first char of a request; mode bit is noise after that.
   task automatic scan_char(inout logic first, input logic [7:0] c, input logic want_marker);
      send_char(c, first, first ? want_marker : 1'($urandom_range(1)));
      first = 1'b0;
   endtask

   function automatic logic [7:0] rand_delim_byte();
      logic [7:0] c;
      if ($urandom_range(3) != 0)
         return $urandom_range(1) ? "a" : "b";
      do
         c = 8'($urandom_range(255));
      while (scan_tracker::marker_stop(c));
      return c;
   endfunction

   // Never NUL, so it cannot end a body by itself.
   function automatic logic [7:0] rand_text_byte();
      case ($urandom_range(9))
         0: return hds_pkg::CH_LF;
         1: return hds_pkg::CH_CR;
         2, 3, 4, 5: return $urandom_range(1) ? "a" : "b";
         default: return 8'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [7:0] pick_stop();
      case ($urandom_range(7))
         0: return hds_pkg::CH_NUL;
         1: return hds_pkg::CH_QUOTE;
         2: return hds_pkg::CH_SPACE;
         3: return hds_pkg::CH_TAB;
         4: return hds_pkg::CH_LF;
         5: return hds_pkg::CH_VT;
         6: return hds_pkg::CH_FF;
         default: return hds_pkg::CH_CR;
      endcase
   endfunction

   task automatic send_marker(input int len, input int blanks, input bit terminate);
      logic first;
      int   i;
      first = 1'b1;
      for (i = 0; i < blanks; i++)
         scan_char(first, $urandom_range(1) ? hds_pkg::CH_SPACE : hds_pkg::CH_TAB, 1'b1);
      for (i = 0; i < len; i++)
         scan_char(first, rand_delim_byte(), 1'b1);
      if (terminate)
         scan_char(first, pick_stop(), 1'b1);
   endtask

   // Body text built around the held delimiter: partial and full line matches.
   task automatic send_body(input bit quote_first, input int max_lines);
      logic first;
      int   dl, lines, i, k, n;
      first = 1'b1;
      dl = int'(book.delim_len);
      if (quote_first || dl == 0) begin
         scan_char(first, quote_first ? hds_pkg::CH_QUOTE : rand_text_byte(), 1'b0);
         return;
      end
      lines = $urandom_range(0, max_lines);
      for (i = 0; i < lines; i++) begin
         case ($urandom_range(3))
            0, 1: begin
               n = $urandom_range(1) ? dl : $urandom_range(0, dl);
               for (k = 0; k < n; k++)
                  scan_char(first, book.store[k], 1'b0);
               n = $urandom_range(1, 5);
               for (k = 0; k < n; k++)
                  scan_char(first, rand_text_byte(), 1'b0);
            end
            2: begin
               n = $urandom_range(0, 6);
               for (k = 0; k < n; k++)
                  scan_char(first, rand_text_byte(), 1'b0);
            end
            default: ;
         endcase
         scan_char(first, $urandom_range(1) ? hds_pkg::CH_LF : hds_pkg::CH_CR, 1'b0);
      end
      n = $urandom_range(9);
      if (n < 6) begin
         for (k = 0; k < dl; k++)
            scan_char(first, book.store[k], 1'b0);
         case ($urandom_range(2))
            0: scan_char(first, hds_pkg::CH_LF, 1'b0);
            1: scan_char(first, hds_pkg::CH_CR, 1'b0);
            default: scan_char(first, hds_pkg::CH_NUL, 1'b0);
         endcase
      end else if (n < 9) begin
         n = $urandom_range(0, 4);
         for (k = 0; k < n; k++)
            scan_char(first, rand_text_byte(), 1'b0);
         scan_char(first, hds_pkg::CH_NUL, 1'b0);
      end
      // otherwise left running; the next request restarts mid-scan
   endtask

   initial begin
      int pick, k, n, idle_mode, next_switch, goal;
      book = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_idling(3);
      // directed: body with no delimiter held fails at once
      send_char("x", 1'b1, 1'b0);
      // blanks skipped, then a three byte marker closed by LF
      send_char(hds_pkg::CH_SPACE, 1'b1, 1'b1);
      send_char(hds_pkg::CH_TAB, 1'b0, 1'b1);
      send_char("E", 1'b0, 1'b0);
      send_char("O", 1'b0, 1'b1);
      send_char("F", 1'b0, 1'b0);
      send_char(hds_pkg::CH_LF, 1'b0, 1'b0);
      // body starting with a quote fails
      send_char(hds_pkg::CH_QUOTE, 1'b1, 1'b0);
      // partial match on the first line, full match closed by CR on the second
      send_char("E", 1'b1, 1'b0);
      send_char("x", 1'b0, 1'b1);
      send_char(hds_pkg::CH_LF, 1'b0, 1'b0);
      send_char("E", 1'b0, 1'b0);
      send_char("O", 1'b0, 1'b0);
      send_char("F", 1'b0, 1'b0);
      send_char(hds_pkg::CH_CR, 1'b0, 1'b0);
      // idle char is ignored
      send_char(8'h80, 1'b0, 1'b1);
      // empty marker fails
      send_char(hds_pkg::CH_VT, 1'b1, 1'b1);
      // high and low bytes in a marker closed by NUL; body ends on match plus NUL
      send_char(8'hFF, 1'b1, 1'b1);
      send_char(8'h01, 1'b0, 1'b0);
      send_char(hds_pkg::CH_NUL, 1'b0, 1'b0);
      send_char(8'hFF, 1'b1, 1'b0);
      send_char(8'h01, 1'b0, 1'b0);
      send_char(hds_pkg::CH_NUL, 1'b0, 1'b0);
      // marker closed by form feed, then NUL in mid-line ends the body
      send_char("Z", 1'b1, 1'b1);
      send_char(hds_pkg::CH_FF, 1'b0, 1'b0);
      send_char("q", 1'b1, 1'b0);
      send_char(hds_pkg::CH_NUL, 1'b0, 1'b0);
      // abandoned marker leaves its bytes behind, then one closed by a quote
      send_char("Q", 1'b1, 1'b1);
      send_char("R", 1'b0, 1'b0);
      send_char("R", 1'b1, 1'b1);
      send_char(hds_pkg::CH_QUOTE, 1'b0, 1'b0);

      // over-long marker: the tail is consumed but not stored
      send_marker(130, 0, 1'b1);
      send_body(1'b0, 1);

      // random part; first phase runs flat out against the receiver hold-off
      idle_mode = 0;
      set_idling(idle_mode);
      pressure_on <= 1'b1;
      next_switch = used_items + PHASE_ITEMS;
      goal = used_items + RANDOM_ITEMS;
      while (used_items < goal) begin
         if (used_items >= next_switch) begin
            idle_mode = (idle_mode + 1) % 4;
            set_idling(idle_mode);
            next_switch = used_items + PHASE_ITEMS;
         end
         pick = $urandom_range(99);
         if (pick < 45) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            send_marker(n, $urandom_range(0, 2), 1'b1);
            send_body(1'b0, 4);
         end else if (pick < 60) begin
            send_body($urandom_range(5) == 0, 4);
         end else if (pick < 72) begin
            send_marker($urandom_range(0, 3), $urandom_range(0, 1), 1'($urandom_range(1)));
         end else begin
            n = $urandom_range(3, 12);
            for (k = 0; k < n; k++)
               send_char(8'($urandom_range(255)), $urandom_range(5) == 0,
                         1'($urandom_range(1)));
         end
      end

      req_valid <= 1'b0;
      while (book.expected_flags.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (book.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ heredoc_delimiter_scanner_core.f @@
src/hds_pkg.sv
src/hds_ram.sv
src/hds_front.sv
src/hds_queue.sv
src/hds_back.sv
src/heredoc_delimiter_scanner_core.sv
src/hds_checker.sv
tb/sv/heredoc_delimiter_scanner_core_test.sv
